/* sv/modular_exponentiation_defines.svh */
// assertion macros for the modular exponentiation block
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define MEXP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mexp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  localparam logic [WIDTH-1:0] ONE_W = {{(WIDTH-1){1'b0}}, 1'b1};
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  typedef struct packed {
    logic start;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

  // (x + y) mod m for x, y below m; a zero modulus stands for 2^WIDTH
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] sum;
    logic [WIDTH:0] dif;
    sum = {1'b0, x} + {1'b0, y};
    dif = sum - {1'b0, m};
    if ((m != '0) && (sum >= {1'b0, m})) begin
      return dif[WIDTH-1:0];
    end
    return sum[WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/mexp_mulmod.sv */
`timescale 1ns / 1ps
`default_nettype none

module mexp_mulmod (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mexp_pkg::mul_ctl_t           ctl_i,
  input  wire logic [mexp_pkg::WIDTH-1:0]   a_i,
  input  wire logic [mexp_pkg::WIDTH-1:0]   b_i,
  input  wire logic [mexp_pkg::WIDTH-1:0]   modulus_i,
  output mexp_pkg::mul_sts_t                sts_o,
  output logic [mexp_pkg::WIDTH-1:0]        product_o
);

  logic [mexp_pkg::WIDTH-1:0] x_q, x_d;
  logic [mexp_pkg::WIDTH-1:0] y_q, y_d;
  logic [mexp_pkg::WIDTH-1:0] acc_q, acc_d;
  logic [mexp_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  // lsb-first shift and add: acc gathers x * 2^i, x doubles each step
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      if (y_q[0]) begin
        acc_d = mexp_pkg::add_mod(acc_q, x_q, modulus_i);
      end
      x_d   = mexp_pkg::add_mod(x_q, x_q, modulus_i);
      y_d   = y_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == mexp_pkg::CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (ctl_i.start) begin
      x_d    = a_i;
      y_d    = b_i;
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    cnt_q <= cnt_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign product_o  = acc_q;

endmodule

`default_nettype wire

/* sv/modular_exponentiation.sv */
// sequence: reduce the base mod m, then for each of the 32 exponent bits, msb first,
// square and, for a set bit, multiply; a zero exponent goes straight to the output
// throughput: one transaction at a time, set by the 32-step shared mod multiplier
// reset: asynchronous active low, clears the sequencer and output valid, modulus to 1
`timescale 1ns / 1ps
`default_nettype none
`include "modular_exponentiation_defines.svh"

module modular_exponentiation (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [mexp_pkg::WIDTH-1:0] cfg_modulus_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [mexp_pkg::WIDTH-1:0] base_i,
  input  wire logic [mexp_pkg::WIDTH-1:0] exponent_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [mexp_pkg::WIDTH-1:0]      power_mod_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_SQR  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [mexp_pkg::WIDTH-1:0] modulus_q;
  logic [mexp_pkg::WIDTH-1:0] acc_q, acc_d;
  logic [mexp_pkg::WIDTH-1:0] base_q, base_d;
  logic [mexp_pkg::WIDTH-1:0] exp_q, exp_d;
  logic [mexp_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [mexp_pkg::WIDTH-1:0] out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  mexp_pkg::mul_ctl_t         mul_ctl;
  mexp_pkg::mul_sts_t         mul_sts;
  logic [mexp_pkg::WIDTH-1:0] mul_a, mul_b, product;
  logic                       next_bit;

  mexp_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mul_ctl),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .modulus_i (modulus_q),
    .sts_o     (mul_sts),
    .product_o (product)
  );

  always_comb begin
    state_d       = state_q;
    acc_d         = acc_q;
    base_d        = base_q;
    exp_d         = exp_q;
    cnt_d         = cnt_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    mul_ctl.start = 1'b0;
    mul_a         = acc_q;
    mul_b         = acc_q;
    next_bit      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (exponent_i == '0) begin
            acc_d   = mexp_pkg::ONE_W;
            state_d = ST_OUT;
          end else begin
            // reduce the base first as 1 * base mod m
            mul_ctl.start = 1'b1;
            mul_a         = mexp_pkg::ONE_W;
            mul_b         = base_i;
            exp_d         = exponent_i;
            cnt_d         = '0;
            acc_d         = (modulus_q == mexp_pkg::ONE_W) ? '0 : mexp_pkg::ONE_W;
            state_d       = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (mul_sts.done) begin
          base_d        = product;
          mul_ctl.start = 1'b1;
          state_d       = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mul_sts.done) begin
          acc_d = product;
          if (exp_q[mexp_pkg::WIDTH-1]) begin
            mul_ctl.start = 1'b1;
            mul_a         = product;
            mul_b         = base_q;
            state_d       = ST_MUL;
          end else begin
            next_bit = 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (mul_sts.done) begin
          acc_d    = product;
          next_bit = 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = acc_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (next_bit) begin
      if (cnt_q == mexp_pkg::CNT_LAST) begin
        state_d = ST_OUT;
      end else begin
        cnt_d         = cnt_q + 1'b1;
        exp_d         = exp_q << 1;
        mul_ctl.start = 1'b1;
        mul_a         = product;
        mul_b         = product;
        state_d       = ST_SQR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      modulus_q   <= mexp_pkg::ONE_W;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        modulus_q <= cfg_modulus_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign power_mod_o = out_q;

  `MEXP_ASSERT(a_ready_unit_idle, !in_ready_o || !mul_sts.busy, "ready while multiplier busy")
  `MEXP_ASSERT(a_start_when_free, !mul_ctl.start || !mul_sts.busy, "multiplier started while busy")
  `MEXP_ASSERT(a_done_in_work, !mul_sts.done || state_q == ST_RED || state_q == ST_SQR || state_q == ST_MUL, "multiplier done outside a work state")
  `MEXP_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")

endmodule

`default_nettype wire
